// ----- rtl/tes_pkg.sv -----
// Shared types and constants for the text encoding sniffer.
// No dependencies; every other file imports this package.
`default_nettype none

package tes_pkg;

    // Encoding reported on the last byte of a buffer
    typedef enum logic [1:0] {
        ENC_MBCS    = 2'd0,
        ENC_UTF8    = 2'd1,
        ENC_UTF16LE = 2'd2,
        ENC_UTF16BE = 2'd3
    } enc_kind_t;

    // Byte order marks
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    // Surrogate ranges of UTF-16
    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

    // UTF-8 lead byte masks and patterns
    localparam logic [7:0] U8_CONT_MASK = 8'hC0;
    localparam logic [7:0] U8_CONT_PAT  = 8'h80;
    localparam logic [7:0] U8_L2_MASK   = 8'hE0;
    localparam logic [7:0] U8_L2_PAT    = 8'hC0;
    localparam logic [7:0] U8_L3_MASK   = 8'hF0;
    localparam logic [7:0] U8_L3_PAT    = 8'hE0;
    localparam logic [7:0] U8_L4_MASK   = 8'hF8;
    localparam logic [7:0] U8_L4_PAT    = 8'hF0;
    localparam logic [7:0] U8_L5_MASK   = 8'hFC;
    localparam logic [7:0] U8_L5_PAT    = 8'hF8;
    localparam logic [7:0] U8_L6_MASK   = 8'hFE;
    localparam logic [7:0] U8_L6_PAT    = 8'hFC;

    // Progress of one UTF-16 byte order scan
    typedef struct packed {
        logic ok;
        logic need;
        logic seen;
    } u16_scan_t;

    localparam u16_scan_t U16_SCAN_INIT = '{ok: 1'b1, need: 1'b0, seen: 1'b0};

endpackage

`default_nettype wire

// ----- rtl/tes_if.sv -----
// Valid/ready channel interfaces for the sniffer: byte beats in, verdict beats out.
// Depends on tes_pkg for the encoding type.
`default_nettype none

interface tes_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tes_verdict_if
    import tes_pkg::*;
;
    logic       valid;
    logic       ready;
    enc_kind_t  encoding_kind;
    logic       contains_bom;
    logic       maybe_mbcs;
    logic       maybe_utf8;
    logic       maybe_utf16le;
    logic       maybe_utf16be;
    logic       le_surrogates_seen;
    logic       be_surrogates_seen;
    logic [2:0] candidate_count;
    logic       needs_further_test;

    modport source (
        output valid, output encoding_kind, output contains_bom,
        output maybe_mbcs, output maybe_utf8, output maybe_utf16le, output maybe_utf16be,
        output le_surrogates_seen, output be_surrogates_seen,
        output candidate_count, output needs_further_test,
        input ready
    );
    modport sink (
        input valid, input encoding_kind, input contains_bom,
        input maybe_mbcs, input maybe_utf8, input maybe_utf16le, input maybe_utf16be,
        input le_surrogates_seen, input be_surrogates_seen,
        input candidate_count, input needs_further_test,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/text_encoding_sniffer.sv -----
// Text encoding sniffer: BOM detection plus MBCS / UTF-8 / UTF-16LE / UTF-16BE checks.
// Depends on tes_pkg and the channel interfaces in tes_if.sv.
//
// The block takes one byte beat per cycle and emits one verdict beat per buffer,
// on the beat marked last_byte. A byte is registered on acceptance, the
// per-buffer state and the verdict are updated from that register, and the
// verdict beat waits in the output register until it is taken. The byte rate
// is one per cycle; the input only pauses while a finished verdict waits in
// the output register and a second last byte reaches the input register
// behind it. After each verdict the state returns to its reset values, so the
// next buffer may follow at once.
`default_nettype none

module text_encoding_sniffer
    import tes_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tes_byte_if.sink      bytes,
    tes_verdict_if.source verdict
);

    // Check one 16-bit word against the surrogate pairing rules
    function automatic u16_scan_t scan_word(input u16_scan_t s, input logic [15:0] w);
        u16_scan_t r;
        logic      is_hi;
        logic      is_lo;
        r     = s;
        is_hi = (w >= HI_SURR_LO) && (w <= HI_SURR_HI);
        is_lo = (w >= LO_SURR_LO) && (w <= LO_SURR_HI);
        if (s.ok)
        begin
            if (w == 16'h0000)
            begin
                r.ok = 1'b0;
            end
            else if (s.need)
            begin
                if (is_lo)
                begin
                    r.need = 1'b0;
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            else if (is_hi)
            begin
                r.need = 1'b1;
                r.seen = 1'b1;
            end
            else if (is_lo)
            begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Per-buffer state
    logic [1:0] pos_reg,     pos_next;
    logic [2:0] bom_reg,     bom_next;
    logic       mbcs_ok_reg, mbcs_ok_next;
    logic       u8_ok_reg,   u8_ok_next;
    logic [2:0] u8_pend_reg, u8_pend_next;
    logic [7:0] held_reg,    held_next;
    logic       phase_reg,   phase_next;
    u16_scan_t  le_reg,      le_next;
    u16_scan_t  be_reg,      be_next;

    // Output stage
    logic       out_valid_reg;
    enc_kind_t  kind_reg;
    logic       bom_flag_reg;
    logic       mbcs_reg;
    logic       utf8_reg;
    logic       le_ok_out_reg;
    logic       be_ok_out_reg;
    logic       le_seen_reg;
    logic       be_seen_reg;
    logic [2:0] cnt_reg;
    logic       need_reg;

    logic       out_free;
    logic       advance;
    logic       emit;

    // Values the buffer would have after this byte
    logic [2:0] bom_upd;
    logic [1:0] pos_upd;
    logic       mbcs_upd;
    logic       u8_ok_upd;
    logic [2:0] u8_pend_upd;
    logic       phase_upd;
    u16_scan_t  le_upd;
    u16_scan_t  be_upd;
    logic [7:0] mark_byte;

    // Verdict fields
    logic       m8;
    logic       mle;
    logic       mbe;
    logic [2:0] cnt;
    logic       has_bom;
    enc_kind_t  kind;

    assign out_free      = !out_valid_reg || verdict.ready;
    // A non-last byte never needs the output register
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = advance && in_last_reg;
    assign bytes.ready   = !in_valid_reg || advance;

    // Update the buffer state from the registered byte
    always_comb
    begin
        unique case (pos_reg)
            2'd0:    mark_byte = BOM8_B0;
            2'd1:    mark_byte = BOM8_B1;
            default: mark_byte = BOM8_B2;
        endcase

        bom_upd = bom_reg;
        if (pos_reg != 2'd3 && in_byte_reg != mark_byte)
        begin
            bom_upd[0] = 1'b0;
        end
        if (pos_reg < 2'd2)
        begin
            if (in_byte_reg != ((pos_reg == 2'd1) ? BOM16_FE : BOM16_FF))
            begin
                bom_upd[1] = 1'b0;
            end
            if (in_byte_reg != ((pos_reg == 2'd1) ? BOM16_FF : BOM16_FE))
            begin
                bom_upd[2] = 1'b0;
            end
        end
        pos_upd  = (pos_reg == 2'd3) ? 2'd3 : pos_reg + 2'd1;
        mbcs_upd = mbcs_ok_reg && (in_byte_reg != 8'h00);

        // UTF-8 continuation or lead byte
        u8_ok_upd = u8_ok_reg;
        if (u8_pend_reg != 3'd0)
        begin
            if ((in_byte_reg & U8_CONT_MASK) != U8_CONT_PAT)
            begin
                u8_ok_upd = 1'b0;
            end
            u8_pend_upd = u8_pend_reg - 3'd1;
        end
        else
        begin
            u8_pend_upd = 3'd0;
            priority if (in_byte_reg == 8'h00)
            begin
                u8_ok_upd = 1'b0;
            end
            else if (!in_byte_reg[7])
            begin
                u8_pend_upd = 3'd0;
            end
            else if ((in_byte_reg & U8_L2_MASK) == U8_L2_PAT)
            begin
                u8_pend_upd = 3'd1;
            end
            else if ((in_byte_reg & U8_L3_MASK) == U8_L3_PAT)
            begin
                u8_pend_upd = 3'd2;
            end
            else if ((in_byte_reg & U8_L4_MASK) == U8_L4_PAT)
            begin
                u8_pend_upd = 3'd3;
            end
            else if ((in_byte_reg & U8_L5_MASK) == U8_L5_PAT)
            begin
                u8_pend_upd = 3'd4;
            end
            else if ((in_byte_reg & U8_L6_MASK) == U8_L6_PAT)
            begin
                u8_pend_upd = 3'd5;
            end
            else
            begin
                // stray continuation, FE or FF
                u8_ok_upd = 1'b0;
            end
        end

        // UTF-16 words complete on every second byte
        le_upd    = le_reg;
        be_upd    = be_reg;
        held_next = held_reg;
        if (!phase_reg)
        begin
            held_next = in_byte_reg;
            phase_upd = 1'b1;
        end
        else
        begin
            le_upd    = scan_word(le_reg, {in_byte_reg, held_reg});
            be_upd    = scan_word(be_reg, {held_reg, in_byte_reg});
            phase_upd = 1'b0;
        end

        // Hold, advance, or restart after the last byte
        pos_next     = pos_reg;
        bom_next     = bom_reg;
        mbcs_ok_next = mbcs_ok_reg;
        u8_ok_next   = u8_ok_reg;
        u8_pend_next = u8_pend_reg;
        phase_next   = phase_reg;
        le_next      = le_reg;
        be_next      = be_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                pos_next     = 2'd0;
                bom_next     = 3'b111;
                mbcs_ok_next = 1'b1;
                u8_ok_next   = 1'b1;
                u8_pend_next = 3'd0;
                phase_next   = 1'b0;
                le_next      = U16_SCAN_INIT;
                be_next      = U16_SCAN_INIT;
            end
            else
            begin
                pos_next     = pos_upd;
                bom_next     = bom_upd;
                mbcs_ok_next = mbcs_upd;
                u8_ok_next   = u8_ok_upd;
                u8_pend_next = u8_pend_upd;
                phase_next   = phase_upd;
                le_next      = le_upd;
                be_next      = be_upd;
            end
        end
    end

    // Form the verdict from the updated state
    always_comb
    begin
        m8  = u8_ok_upd && (u8_pend_upd == 3'd0);
        mle = !phase_upd && le_upd.ok && !le_upd.need;
        mbe = !phase_upd && be_upd.ok && !be_upd.need;
        cnt = {2'b00, mbcs_upd} + {2'b00, m8} + {2'b00, mle} + {2'b00, mbe};

        has_bom = 1'b1;
        priority if (pos_upd == 2'd3 && bom_upd[0])
        begin
            kind = ENC_UTF8;
        end
        else if (pos_upd >= 2'd2 && bom_upd[1])
        begin
            kind = ENC_UTF16LE;
        end
        else if (pos_upd >= 2'd2 && bom_upd[2])
        begin
            kind = ENC_UTF16BE;
        end
        else
        begin
            has_bom = 1'b0;
            kind    = ENC_MBCS;
            if (cnt == 3'd1)
            begin
                priority if (m8)
                begin
                    kind = ENC_UTF8;
                end
                else if (mle)
                begin
                    kind = ENC_UTF16LE;
                end
                else if (mbe)
                begin
                    kind = ENC_UTF16BE;
                end
                else
                begin
                    kind = ENC_MBCS;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            bom_reg       <= 3'b111;
            mbcs_ok_reg   <= 1'b1;
            u8_ok_reg     <= 1'b1;
            u8_pend_reg   <= 3'd0;
            held_reg      <= 8'h00;
            phase_reg     <= 1'b0;
            le_reg        <= U16_SCAN_INIT;
            be_reg        <= U16_SCAN_INIT;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            pos_reg     <= pos_next;
            bom_reg     <= bom_next;
            mbcs_ok_reg <= mbcs_ok_next;
            u8_ok_reg   <= u8_ok_next;
            u8_pend_reg <= u8_pend_next;
            if (advance)
            begin
                held_reg <= held_next;
            end
            phase_reg   <= phase_next;
            le_reg      <= le_next;
            be_reg      <= be_next;
        end
    end

    // Payload registers: capture the byte beat and the verdict
    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_byte_reg <= bytes.data_byte;
            in_last_reg <= bytes.last_byte;
        end
        if (emit)
        begin
            kind_reg      <= kind;
            bom_flag_reg  <= has_bom;
            mbcs_reg      <= mbcs_upd;
            utf8_reg      <= m8;
            le_ok_out_reg <= mle;
            be_ok_out_reg <= mbe;
            le_seen_reg   <= !phase_upd && le_upd.seen;
            be_seen_reg   <= !phase_upd && be_upd.seen;
            cnt_reg       <= cnt;
            need_reg      <= !has_bom && (cnt > 3'd1);
        end
    end

    assign verdict.valid              = out_valid_reg;
    assign verdict.encoding_kind      = kind_reg;
    assign verdict.contains_bom       = bom_flag_reg;
    assign verdict.maybe_mbcs         = mbcs_reg;
    assign verdict.maybe_utf8         = utf8_reg;
    assign verdict.maybe_utf16le      = le_ok_out_reg;
    assign verdict.maybe_utf16be      = be_ok_out_reg;
    assign verdict.le_surrogates_seen = le_seen_reg;
    assign verdict.be_surrogates_seen = be_seen_reg;
    assign verdict.candidate_count    = cnt_reg;
    assign verdict.needs_further_test = need_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for text_encoding_sniffer: byte buffers in, one verdict per buffer.
// Depends on tes_pkg and the channel interfaces of tes_if.sv; the expected verdict
// is rebuilt per byte by an in-bench scanner and matched in order against the block.
`default_nettype none

module tb;
    import tes_pkg::*;

    localparam int RANDOM_BYTES = 1900;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int TAIL_CYCLES  = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        enc_kind_t  kind;
        logic       bom;
        logic       mbcs;
        logic       utf8;
        logic       utf16le;
        logic       utf16be;
        logic       le_surr;
        logic       be_surr;
        logic [2:0] count;
        logic       further;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    // Tracks one buffer byte by byte and holds the verdicts still owed by the block
    class sniff_scoreboard;
        logic [1:0] pos;
        logic [2:0] bom_live;
        bit         mbcs_ok;
        bit         u8_ok;
        logic [2:0] u8_left;
        logic [7:0] held;
        bit         phase;
        u16_scan_t  le_scan;
        u16_scan_t  be_scan;
        verdict_t   pending[$];
        int         errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos      = 2'd0;
            bom_live = 3'b111;
            mbcs_ok  = 1'b1;
            u8_ok    = 1'b1;
            u8_left  = 3'd0;
            held     = 8'h00;
            phase    = 1'b0;
            le_scan  = U16_SCAN_INIT;
            be_scan  = U16_SCAN_INIT;
        endfunction

        // Advance one UTF-16 scan by a word; a failed scan stays frozen
        function automatic u16_scan_t scan_word(u16_scan_t s, logic [15:0] w);
            bit hi;
            bit lo;
            hi = (w >= HI_SURR_LO) && (w <= HI_SURR_HI);
            lo = (w >= LO_SURR_LO) && (w <= LO_SURR_HI);
            if (!s.ok)
                return s;
            if (w == 16'h0000) begin
                s.ok = 1'b0;
                return s;
            end
            if (s.need) begin
                if (lo)
                    s.need = 1'b0;
                else
                    s.ok = 1'b0;
            end else if (hi) begin
                s.need = 1'b1;
                s.seen = 1'b1;
            end else if (lo) begin
                s.ok = 1'b0;
            end
            return s;
        endfunction

        // Number of continuation bytes a lead byte announces
        function automatic logic [2:0] cont_count(logic [7:0] b, output bit bad);
            bad = 1'b0;
            if (b == 8'h00) begin
                bad = 1'b1;
                return 3'd0;
            end
            if (b[7] == 1'b0)                       return 3'd0;
            if ((b & U8_L2_MASK) == U8_L2_PAT)      return 3'd1;
            if ((b & U8_L3_MASK) == U8_L3_PAT)      return 3'd2;
            if ((b & U8_L4_MASK) == U8_L4_PAT)      return 3'd3;
            if ((b & U8_L5_MASK) == U8_L5_PAT)      return 3'd4;
            if ((b & U8_L6_MASK) == U8_L6_PAT)      return 3'd5;
            bad = 1'b1;
            return 3'd0;
        endfunction

        // Fold one accepted byte into the scan; queue a verdict on the last one
        function void note_byte(logic [7:0] b, bit last);
            logic [7:0] mark;
            logic [2:0] n;
            bit         bad;
            bit         m8;
            bit         mle;
            bit         mbe;
            int         cnt;
            verdict_t   v;

            mark = (pos == 2'd0) ? BOM8_B0 : (pos == 2'd1) ? BOM8_B1 : BOM8_B2;
            if (pos < 2'd3 && b != mark)
                bom_live[0] = 1'b0;
            if (pos < 2'd2) begin
                if (b != ((pos != 2'd0) ? BOM16_FE : BOM16_FF))
                    bom_live[1] = 1'b0;
                if (b != ((pos != 2'd0) ? BOM16_FF : BOM16_FE))
                    bom_live[2] = 1'b0;
            end
            if (pos < 2'd3)
                pos = pos + 2'd1;

            if (b == 8'h00)
                mbcs_ok = 1'b0;

            if (u8_left != 3'd0) begin
                if ((b & U8_CONT_MASK) != U8_CONT_PAT)
                    u8_ok = 1'b0;
                u8_left = u8_left - 3'd1;
            end else begin
                n = cont_count(b, bad);
                if (bad)
                    u8_ok = 1'b0;
                u8_left = n;
            end

            if (!phase) begin
                held  = b;
                phase = 1'b1;
            end else begin
                le_scan = scan_word(le_scan, {b, held});
                be_scan = scan_word(be_scan, {held, b});
                phase   = 1'b0;
            end

            if (!last)
                return;

            m8  = u8_ok && (u8_left == 3'd0);
            mle = !phase && le_scan.ok && !le_scan.need;
            mbe = !phase && be_scan.ok && !be_scan.need;
            cnt = int'(mbcs_ok) + int'(m8) + int'(mle) + int'(mbe);

            v.bom = 1'b1;
            if (pos >= 2'd3 && bom_live[0])
                v.kind = ENC_UTF8;
            else if (pos >= 2'd2 && bom_live[1])
                v.kind = ENC_UTF16LE;
            else if (pos >= 2'd2 && bom_live[2])
                v.kind = ENC_UTF16BE;
            else begin
                v.bom  = 1'b0;
                v.kind = ENC_MBCS;
                if (cnt == 1) begin
                    if (m8)
                        v.kind = ENC_UTF8;
                    else if (mle)
                        v.kind = ENC_UTF16LE;
                    else if (mbe)
                        v.kind = ENC_UTF16BE;
                end
            end
            v.mbcs    = mbcs_ok;
            v.utf8    = m8;
            v.utf16le = mle;
            v.utf16be = mbe;
            v.le_surr = phase ? 1'b0 : le_scan.seen;
            v.be_surr = phase ? 1'b0 : be_scan.seen;
            v.count   = 3'(cnt);
            v.further = !v.bom && (cnt > 1);
            pending.push_back(v);
            restart();
        endfunction

        function string show(verdict_t v);
            return $sformatf("kind=%0d bom=%0b mbcs=%0b u8=%0b le=%0b be=%0b lsur=%0b bsur=%0b cnt=%0d more=%0b",
                             v.kind, v.bom, v.mbcs, v.utf8, v.utf16le, v.utf16be,
                             v.le_surr, v.be_surr, v.count, v.further);
        endfunction

        // Match one verdict beat against the oldest one owed
        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("tb: unexpected verdict %s", show(got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("tb: verdict mismatch");
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tes_byte_if    bytes_ch ();
    tes_verdict_if verdict_ch ();

    text_encoding_sniffer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .verdict (verdict_ch)
    );

    sniff_scoreboard sb = new();
    byte_beat_t      stream_q[$];
    logic [7:0]      buf_q[$];
    int              idle_cycles;
    int              send_stretch;
    bit              send_busy;
    int              recv_stretch;
    bit              recv_busy;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Per-beat wait: random stretches of back-to-back traffic, otherwise a gap drawn at random per beat
    function automatic int draw_gap(inout int stretch, inout bit busy);
        if (stretch == 0) begin
            stretch = $urandom_range(16, 64);
            busy    = ($urandom_range(0, 2) == 0);
        end
        stretch--;
        return busy ? 0 : $urandom_range(0, 12);
    endfunction

    // Move the buffer under construction onto the byte stream, marking its last beat
    task automatic emit_buffer();
        byte_beat_t beat;
        if (buf_q.size() == 0)
            buf_q.push_back(8'($urandom_range(0, 255)));
        foreach (buf_q[i]) begin
            beat.data = buf_q[i];
            beat.last = (i == buf_q.size() - 1);
            stream_q.push_back(beat);
        end
        buf_q.delete();
    endtask

    // Build one random buffer: well-formed text of some encoding, maybe marked,
    // maybe damaged, or plain noise
    task automatic build_random_buffer();
        int         content;
        int         units;
        int         idx;
        logic [15:0] w;
        logic [15:0] lo;
        logic [2:0] extra;
        logic [7:0] lead;
        content = $urandom_range(0, 9);
        units   = $urandom_range(1, 6);
        if (content < 4) begin
            // UTF-8 text, lead lengths one to six
            if ($urandom_range(0, 4) == 0) begin
                buf_q.push_back(BOM8_B0);
                buf_q.push_back(BOM8_B1);
                buf_q.push_back(BOM8_B2);
            end
            repeat (units) begin
                extra = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 5));
                case (extra)
                    3'd0:    lead = 8'($urandom_range(1, 127));
                    3'd1:    lead = U8_L2_PAT | 8'($urandom_range(0, 31));
                    3'd2:    lead = U8_L3_PAT | 8'($urandom_range(0, 15));
                    3'd3:    lead = U8_L4_PAT | 8'($urandom_range(0, 7));
                    3'd4:    lead = U8_L5_PAT | 8'($urandom_range(0, 3));
                    default: lead = U8_L6_PAT | 8'($urandom_range(0, 1));
                endcase
                buf_q.push_back(lead);
                repeat (extra)
                    buf_q.push_back(U8_CONT_PAT | 8'($urandom_range(0, 63)));
            end
        end else if (content < 8) begin
            // UTF-16 text in either byte order, with surrogate pairs
            if ($urandom_range(0, 4) == 0) begin
                buf_q.push_back((content < 6) ? BOM16_FF : BOM16_FE);
                buf_q.push_back((content < 6) ? BOM16_FE : BOM16_FF);
            end
            repeat (units) begin
                lo = 16'h0000;
                case ($urandom_range(0, 3))
                    0: begin
                        w  = HI_SURR_LO | 16'($urandom_range(0, 1023));
                        lo = LO_SURR_LO | 16'($urandom_range(0, 1023));
                    end
                    1: w = 16'($urandom_range(1, 127));
                    default: begin
                        do
                            w = 16'($urandom_range(1, 65535));
                        while (w >= HI_SURR_LO && w <= LO_SURR_HI);
                    end
                endcase
                for (int k = 0; k < ((lo != 16'h0000) ? 2 : 1); k++) begin
                    if (content < 6) begin
                        buf_q.push_back(w[7:0]);
                        buf_q.push_back(w[15:8]);
                    end else begin
                        buf_q.push_back(w[15:8]);
                        buf_q.push_back(w[7:0]);
                    end
                    w = lo;
                end
            end
        end else begin
            // noise biased toward the interesting byte values
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 5))
                    0: buf_q.push_back(8'h00);
                    1: buf_q.push_back(($urandom_range(0, 1) == 0) ? BOM16_FF : BOM16_FE);
                    2: buf_q.push_back(U8_CONT_PAT | 8'($urandom_range(0, 63)));
                    3: buf_q.push_back(8'($urandom_range(8'hD8, 8'hDF)));
                    default: buf_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end

        // damage a share of the well-formed buffers
        if (content < 8 && $urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, buf_q.size() - 1);
            case ($urandom_range(0, 3))
                0: if (buf_q.size() > 1) void'(buf_q.pop_back());
                1: buf_q.insert(idx, 8'h00);
                2: buf_q[idx] = 8'($urandom_range(0, 255));
                default: buf_q.push_front(8'($urandom_range(0, 255)));
            endcase
        end
        emit_buffer();
    endtask

    // Stall watchdog: end the run when nothing moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (bytes_ch.valid && bytes_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Verdict side: random backpressure plus one long hold-off to fill the block
    initial begin : verdict_sink
        int       gap;
        int       taken;
        verdict_t got;
        taken        = 0;
        recv_stretch = 0;
        recv_busy    = 1'b0;
        verdict_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = (taken == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(recv_stretch, recv_busy);
            if (gap > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            verdict_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (verdict_ch.valid !== 1'b1);
            got.kind    = verdict_ch.encoding_kind;
            got.bom     = verdict_ch.contains_bom;
            got.mbcs    = verdict_ch.maybe_mbcs;
            got.utf8    = verdict_ch.maybe_utf8;
            got.utf16le = verdict_ch.maybe_utf16le;
            got.utf16be = verdict_ch.maybe_utf16be;
            got.le_surr = verdict_ch.le_surrogates_seen;
            got.be_surr = verdict_ch.be_surrogates_seen;
            got.count   = verdict_ch.candidate_count;
            got.further = verdict_ch.needs_further_test;
            sb.check_verdict(got);
            taken++;
        end
    end

    // Byte side: build the stream, reset, drive every beat, then drain
    initial begin : byte_source
        int gap;
        idle_cycles  = 0;
        send_stretch = 0;
        send_busy    = 1'b0;
        rst_n              <= 1'b0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= 8'h00;
        bytes_ch.last_byte <= 1'b0;

        // directed buffers: single bytes, each mark, surrogates, long lead, strays
        buf_q = '{8'h00};                                  emit_buffer();
        buf_q = '{8'hFF};                                  emit_buffer();
        buf_q = '{8'hC3};                                  emit_buffer();
        buf_q = '{8'hEF, 8'hBB, 8'hBF};                    emit_buffer();
        buf_q = '{8'hFF, 8'hFE};                           emit_buffer();
        buf_q = '{8'hFE, 8'hFF, 8'h00, 8'h41};             emit_buffer();
        buf_q = '{8'h3D, 8'hD8, 8'h00, 8'hDC};             emit_buffer();
        buf_q = '{8'h00, 8'hDC};                           emit_buffer();
        buf_q = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}; emit_buffer();
        buf_q = '{8'h80, 8'h41, 8'h42};                    emit_buffer();
        buf_q = '{8'h61, 8'h62};                           emit_buffer();

        while (stream_q.size() < RANDOM_BYTES + 32)
            build_random_buffer();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stream_q[i]) begin
            gap = draw_gap(send_stretch, send_busy);
            if (gap > 0) begin
                bytes_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            bytes_ch.valid     <= 1'b1;
            bytes_ch.data_byte <= stream_q[i].data;
            bytes_ch.last_byte <= stream_q[i].last;
            do
                @(posedge clk);
            while (bytes_ch.ready !== 1'b1);
            sb.note_byte(stream_q[i].data, stream_q[i].last);
        end
        bytes_ch.valid <= 1'b0;

        // drain outstanding verdicts, then watch for strays
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/tes_pkg.sv
rtl/tes_if.sv
rtl/text_encoding_sniffer.sv
tb/tb.sv
